>>> rtl/glep_pkg.sv
package glep_pkg;

  localparam int MAX_EDGES    = 1024;
  localparam int MAX_VERTICES = 4096;

  localparam int OP_W   = 2;
  localparam int VID_W  = 12;
  localparam int IDX_W  = 10;
  localparam int LIVE_W = 11;

  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int DEG_W  = $clog2(2 * MAX_EDGES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_PRUNE = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DEG_ZERO = 2'd0,
    DEG_INC  = 2'd1,
    DEG_DEC  = 2'd2
  } deg_mode_t;

  typedef enum logic [1:0] {
    EW_NEW  = 2'd0,
    EW_MARK = 2'd1,
    EW_KILL = 2'd2
  } ewr_mode_t;

  typedef enum logic [1:0] {
    RSP_PLAIN = 2'd0,
    RSP_FULL  = 2'd1,
    RSP_QUERY = 2'd2
  } rsp_kind_t;

  typedef struct packed {
    logic             alive;
    logic             mark;
    logic [VID_W-1:0] end_a;
    logic [VID_W-1:0] end_b;
  } edge_ent_t;

  typedef struct packed {
    logic      latch;
    logic      tbl_clr;
    logic      add_commit;
    logic      alive_dec;
    logic      vcnt_clr;
    logic      vcnt_inc;
    logic      ecnt_clr;
    logic      ecnt_inc;
    logic      any_clr;
    logic      any_set;
    logic      da1_cap;
    logic      edge_rd;
    logic      edge_rd_idx;
    logic      edge_wr;
    ewr_mode_t ewr_mode;
    logic      deg_rd;
    logic      deg_wr;
    logic      deg_sel_b;
    logic      deg_src_edge;
    deg_mode_t deg_mode;
    logic      resp;
    rsp_kind_t rsp_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic vcnt_last;
    logic ecnt_last;
    logic tbl_full;
    logic tbl_empty;
    logic vert_ok;
    logic e_alive;
    logic e_mark;
    logic mark_hit;
    logic any_mark;
  } sts_t;

endpackage

>>> rtl/graph_leaf_edge_pruner_top.sv
// Each accepted command ends in a result strobe; a dropped add answers without touching a RAM.
// Prune takes rounds until stable, none on an empty table; a round scans every loaded slot,
// reading both end degrees of each live one, then, if any edge was marked, scans again to
// kill each marked edge and decrement its end degrees, through edge and degree RAMs with
// one read port each. A new command is taken in the cycle its result shows; no result stall.
// After reset, busy stays high while the degree RAM is zeroed; clear runs the same pass.
module graph_leaf_edge_pruner_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [glep_pkg::OP_W-1:0]   in_op,
  input  logic [glep_pkg::VID_W-1:0]  in_vertex_a,
  input  logic [glep_pkg::VID_W-1:0]  in_vertex_b,
  input  logic [glep_pkg::IDX_W-1:0]  in_edge_index,
  output logic                        out_valid,
  output logic                        out_kept,
  output logic [glep_pkg::VID_W-1:0]  out_end_a,
  output logic [glep_pkg::VID_W-1:0]  out_end_b,
  output logic [glep_pkg::LIVE_W-1:0] out_live_edges,
  output logic                        out_table_full
);

  glep_pkg::cmd_t cmd;
  glep_pkg::sts_t sts;

  glep_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  glep_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_vertex_a   (in_vertex_a),
    .in_vertex_b   (in_vertex_b),
    .in_edge_index (in_edge_index),
    .out_valid     (out_valid),
    .out_kept      (out_kept),
    .out_end_a     (out_end_a),
    .out_end_b     (out_end_b),
    .out_live_edges(out_live_edges),
    .out_table_full(out_table_full)
  );

`ifndef SYNTH
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_no_instant_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result one cycle after transfer");

  a_full_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (!out_kept && out_end_a == '0 && out_end_b == '0))
    else $error("table full flagged on query data");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_live_edges) <= glep_pkg::MAX_EDGES))
    else $error("live edge count beyond table size");
`endif

endmodule

>>> rtl/glep_ram.sv
module glep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/glep_dp.sv
module glep_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  glep_pkg::cmd_t              cmd,
  output glep_pkg::sts_t              sts,
  input  logic [glep_pkg::OP_W-1:0]   in_op,
  input  logic [glep_pkg::VID_W-1:0]  in_vertex_a,
  input  logic [glep_pkg::VID_W-1:0]  in_vertex_b,
  input  logic [glep_pkg::IDX_W-1:0]  in_edge_index,
  output logic                        out_valid,
  output logic                        out_kept,
  output logic [glep_pkg::VID_W-1:0]  out_end_a,
  output logic [glep_pkg::VID_W-1:0]  out_end_b,
  output logic [glep_pkg::LIVE_W-1:0] out_live_edges,
  output logic                        out_table_full
);

  glep_pkg::op_t                 op_r;
  logic [glep_pkg::VID_W-1:0]    va_r;
  logic [glep_pkg::VID_W-1:0]    vb_r;
  logic [glep_pkg::IDX_W-1:0]    idx_r;

  logic [glep_pkg::ECNT_W-1:0]   loaded_r, loaded_nxt;
  logic [glep_pkg::ECNT_W-1:0]   alive_cnt_r, alive_cnt_nxt;
  logic [glep_pkg::VIDX_W-1:0]   vcnt_r, vcnt_nxt;
  logic [glep_pkg::EIDX_W-1:0]   ecnt_r, ecnt_nxt;
  logic                          any_r, any_nxt;
  logic                          da1_r;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kept_r, out_kept_nxt;
  logic [glep_pkg::VID_W-1:0]    out_end_a_r, out_end_a_nxt;
  logic [glep_pkg::VID_W-1:0]    out_end_b_r, out_end_b_nxt;
  logic [glep_pkg::LIVE_W-1:0]   out_live_r, out_live_nxt;
  logic                          out_full_r, out_full_nxt;

  glep_pkg::edge_ent_t           e_rd;
  glep_pkg::edge_ent_t           e_wd;
  logic [glep_pkg::EIDX_W-1:0]   e_waddr;
  logic [glep_pkg::EIDX_W-1:0]   e_raddr;

  logic [glep_pkg::DEG_W-1:0]    deg_rd;
  logic [glep_pkg::DEG_W-1:0]    deg_wd;
  logic [glep_pkg::VID_W-1:0]    deg_a;
  logic [glep_pkg::VID_W-1:0]    deg_b;
  logic [glep_pkg::VID_W-1:0]    deg_v;
  logic [glep_pkg::VIDX_W-1:0]   deg_waddr;

  logic                          in_range;
  logic                          deg_one;

  glep_ram #(
    .WIDTH($bits(glep_pkg::edge_ent_t)),
    .DEPTH(glep_pkg::MAX_EDGES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (cmd.edge_wr),
    .waddr(e_waddr),
    .wdata(e_wd),
    .re   (cmd.edge_rd),
    .raddr(e_raddr),
    .rdata(e_rd)
  );

  glep_ram #(
    .WIDTH(glep_pkg::DEG_W),
    .DEPTH(glep_pkg::MAX_VERTICES)
  ) u_deg_ram (
    .clk  (clk),
    .we   (cmd.deg_wr),
    .waddr(deg_waddr),
    .wdata(deg_wd),
    .re   (cmd.deg_rd),
    .raddr(glep_pkg::VIDX_W'(deg_v)),
    .rdata(deg_rd)
  );

  always_comb begin
    e_raddr = cmd.edge_rd_idx ? glep_pkg::EIDX_W'(idx_r) : ecnt_r;
    e_waddr = ecnt_r;
    e_wd    = e_rd;
    case (cmd.ewr_mode)
      glep_pkg::EW_NEW: begin
        e_waddr = glep_pkg::EIDX_W'(loaded_r);
        e_wd    = '{alive: 1'b1, mark: 1'b0, end_a: va_r, end_b: vb_r};
      end
      glep_pkg::EW_MARK: begin
        e_wd.mark = 1'b1;
      end
      glep_pkg::EW_KILL: begin
        e_wd.alive = 1'b0;
        e_wd.mark  = 1'b0;
      end
      default: begin
        e_wd = e_rd;
      end
    endcase
  end

  always_comb begin
    deg_a     = cmd.deg_src_edge ? e_rd.end_a : va_r;
    deg_b     = cmd.deg_src_edge ? e_rd.end_b : vb_r;
    deg_v     = cmd.deg_sel_b ? deg_b : deg_a;
    deg_waddr = glep_pkg::VIDX_W'(deg_v);
    case (cmd.deg_mode)
      glep_pkg::DEG_ZERO: begin
        deg_waddr = vcnt_r;
        deg_wd    = '0;
      end
      glep_pkg::DEG_INC: begin
        deg_wd = deg_rd + glep_pkg::DEG_W'(1);
      end
      glep_pkg::DEG_DEC: begin
        deg_wd = deg_rd - glep_pkg::DEG_W'(deg_rd != '0);
      end
      default: begin
        deg_wd = deg_rd;
      end
    endcase
  end

  assign deg_one  = (deg_rd == glep_pkg::DEG_W'(1));
  assign in_range = (32'(idx_r) < 32'(loaded_r)) && (32'(idx_r) < glep_pkg::MAX_EDGES);

  always_comb begin
    loaded_nxt    = loaded_r;
    alive_cnt_nxt = alive_cnt_r;
    vcnt_nxt      = vcnt_r;
    ecnt_nxt      = ecnt_r;
    any_nxt       = any_r;
    if (cmd.tbl_clr) begin
      loaded_nxt    = '0;
      alive_cnt_nxt = '0;
    end else if (cmd.add_commit) begin
      loaded_nxt    = loaded_r + glep_pkg::ECNT_W'(1);
      alive_cnt_nxt = alive_cnt_r + glep_pkg::ECNT_W'(1);
    end else if (cmd.alive_dec) begin
      alive_cnt_nxt = alive_cnt_r - glep_pkg::ECNT_W'(1);
    end
    if (cmd.vcnt_clr) begin
      vcnt_nxt = '0;
    end else if (cmd.vcnt_inc) begin
      vcnt_nxt = vcnt_r + glep_pkg::VIDX_W'(1);
    end
    if (cmd.ecnt_clr) begin
      ecnt_nxt = '0;
    end else if (cmd.ecnt_inc) begin
      ecnt_nxt = ecnt_r + glep_pkg::EIDX_W'(1);
    end
    if (cmd.any_clr) begin
      any_nxt = 1'b0;
    end else if (cmd.any_set) begin
      any_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = cmd.resp;
    out_kept_nxt  = out_kept_r;
    out_end_a_nxt = out_end_a_r;
    out_end_b_nxt = out_end_b_r;
    out_live_nxt  = out_live_r;
    out_full_nxt  = out_full_r;
    if (cmd.resp) begin
      out_kept_nxt  = 1'b0;
      out_end_a_nxt = '0;
      out_end_b_nxt = '0;
      out_full_nxt  = 1'b0;
      out_live_nxt  = glep_pkg::LIVE_W'(alive_cnt_nxt);
      case (cmd.rsp_kind)
        glep_pkg::RSP_FULL: begin
          out_full_nxt = 1'b1;
        end
        glep_pkg::RSP_QUERY: begin
          if (in_range) begin
            out_kept_nxt  = e_rd.alive;
            out_end_a_nxt = e_rd.end_a;
            out_end_b_nxt = e_rd.end_b;
          end
        end
        default: begin
          out_full_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      alive_cnt_r <= '0;
      vcnt_r      <= '0;
      ecnt_r      <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      alive_cnt_r <= alive_cnt_nxt;
      vcnt_r      <= vcnt_nxt;
      ecnt_r      <= ecnt_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= glep_pkg::op_t'(in_op);
      va_r  <= in_vertex_a;
      vb_r  <= in_vertex_b;
      idx_r <= in_edge_index;
    end
    if (cmd.da1_cap) begin
      da1_r <= deg_one;
    end
    out_kept_r  <= out_kept_nxt;
    out_end_a_r <= out_end_a_nxt;
    out_end_b_r <= out_end_b_nxt;
    out_live_r  <= out_live_nxt;
    out_full_r  <= out_full_nxt;
  end

  always_comb begin
    sts.op        = op_r;
    sts.vcnt_last = (vcnt_r == glep_pkg::VIDX_W'(glep_pkg::MAX_VERTICES - 1));
    sts.ecnt_last = ((glep_pkg::ECNT_W'(ecnt_r) + glep_pkg::ECNT_W'(1)) == loaded_r);
    sts.tbl_full  = (loaded_r == glep_pkg::ECNT_W'(glep_pkg::MAX_EDGES));
    sts.tbl_empty = (loaded_r == '0);
    sts.vert_ok   = (32'(va_r) < glep_pkg::MAX_VERTICES) &&
                    (32'(vb_r) < glep_pkg::MAX_VERTICES);
    sts.e_alive   = e_rd.alive;
    sts.e_mark    = e_rd.mark;
    sts.mark_hit  = da1_r | deg_one;
    sts.any_mark  = any_r;
  end

  assign out_valid      = out_valid_r;
  assign out_kept       = out_kept_r;
  assign out_end_a      = out_end_a_r;
  assign out_end_b      = out_end_b_r;
  assign out_live_edges = out_live_r;
  assign out_table_full = out_full_r;

endmodule

>>> rtl/glep_ctrl.sv
module glep_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  glep_pkg::sts_t sts,
  output glep_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLR    = 16'b0000_0000_0000_0001,
    S_IDLE   = 16'b0000_0000_0000_0010,
    S_DISP   = 16'b0000_0000_0000_0100,
    S_ADD_WA = 16'b0000_0000_0000_1000,
    S_ADD_RB = 16'b0000_0000_0001_0000,
    S_ADD_WB = 16'b0000_0000_0010_0000,
    S_Q_RESP = 16'b0000_0000_0100_0000,
    S_P1_RD  = 16'b0000_0000_1000_0000,
    S_P1_RA  = 16'b0000_0001_0000_0000,
    S_P1_RB  = 16'b0000_0010_0000_0000,
    S_P1_EV  = 16'b0000_0100_0000_0000,
    S_P2_RD  = 16'b0000_1000_0000_0000,
    S_P2_CHK = 16'b0001_0000_0000_0000,
    S_P2_WA  = 16'b0010_0000_0000_0000,
    S_P2_RB  = 16'b0100_0000_0000_0000,
    S_P2_WB  = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_clr_r, resp_clr_nxt;
  logic   marked;

  always_comb begin
    state_nxt    = state_r;
    resp_clr_nxt = resp_clr_r;
    cmd          = '0;
    marked       = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.deg_wr   = 1'b1;
        cmd.deg_mode = glep_pkg::DEG_ZERO;
        cmd.vcnt_inc = 1'b1;
        if (sts.vcnt_last) begin
          cmd.resp     = resp_clr_r;
          cmd.rsp_kind = glep_pkg::RSP_PLAIN;
          resp_clr_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          glep_pkg::OP_CLEAR: begin
            cmd.tbl_clr  = 1'b1;
            cmd.vcnt_clr = 1'b1;
            resp_clr_nxt = 1'b1;
            state_nxt    = S_CLR;
          end
          glep_pkg::OP_ADD: begin
            if (sts.tbl_full) begin
              cmd.resp     = 1'b1;
              cmd.rsp_kind = glep_pkg::RSP_FULL;
              state_nxt    = S_IDLE;
            end else if (!sts.vert_ok) begin
              cmd.resp     = 1'b1;
              cmd.rsp_kind = glep_pkg::RSP_PLAIN;
              state_nxt    = S_IDLE;
            end else begin
              cmd.edge_wr  = 1'b1;
              cmd.ewr_mode = glep_pkg::EW_NEW;
              cmd.deg_rd   = 1'b1;
              state_nxt    = S_ADD_WA;
            end
          end
          glep_pkg::OP_PRUNE: begin
            if (sts.tbl_empty) begin
              cmd.resp     = 1'b1;
              cmd.rsp_kind = glep_pkg::RSP_PLAIN;
              state_nxt    = S_IDLE;
            end else begin
              cmd.ecnt_clr = 1'b1;
              cmd.any_clr  = 1'b1;
              state_nxt    = S_P1_RD;
            end
          end
          glep_pkg::OP_QUERY: begin
            cmd.edge_rd     = 1'b1;
            cmd.edge_rd_idx = 1'b1;
            state_nxt       = S_Q_RESP;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ADD_WA: begin
        cmd.deg_wr   = 1'b1;
        cmd.deg_mode = glep_pkg::DEG_INC;
        state_nxt    = S_ADD_RB;
      end
      S_ADD_RB: begin
        cmd.deg_rd    = 1'b1;
        cmd.deg_sel_b = 1'b1;
        state_nxt     = S_ADD_WB;
      end
      S_ADD_WB: begin
        cmd.deg_wr     = 1'b1;
        cmd.deg_sel_b  = 1'b1;
        cmd.deg_mode   = glep_pkg::DEG_INC;
        cmd.add_commit = 1'b1;
        cmd.resp       = 1'b1;
        cmd.rsp_kind   = glep_pkg::RSP_PLAIN;
        state_nxt      = S_IDLE;
      end
      S_Q_RESP: begin
        cmd.resp     = 1'b1;
        cmd.rsp_kind = glep_pkg::RSP_QUERY;
        state_nxt    = S_IDLE;
      end
      S_P1_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_P1_RA;
      end
      S_P1_RA, S_P1_EV: begin
        if (state_r == S_P1_RA && sts.e_alive) begin
          cmd.deg_rd       = 1'b1;
          cmd.deg_src_edge = 1'b1;
          state_nxt        = S_P1_RB;
        end else begin
          if (state_r == S_P1_EV && sts.mark_hit) begin
            cmd.edge_wr  = 1'b1;
            cmd.ewr_mode = glep_pkg::EW_MARK;
            cmd.any_set  = 1'b1;
            marked       = 1'b1;
          end
          if (!sts.ecnt_last) begin
            cmd.ecnt_inc = 1'b1;
            state_nxt    = S_P1_RD;
          end else if (sts.any_mark || marked) begin
            cmd.ecnt_clr = 1'b1;
            state_nxt    = S_P2_RD;
          end else begin
            cmd.resp     = 1'b1;
            cmd.rsp_kind = glep_pkg::RSP_PLAIN;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_P1_RB: begin
        cmd.da1_cap      = 1'b1;
        cmd.deg_rd       = 1'b1;
        cmd.deg_src_edge = 1'b1;
        cmd.deg_sel_b    = 1'b1;
        state_nxt        = S_P1_EV;
      end
      S_P2_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_P2_CHK;
      end
      S_P2_CHK, S_P2_WB: begin
        if (state_r == S_P2_CHK && sts.e_mark) begin
          cmd.edge_wr      = 1'b1;
          cmd.ewr_mode     = glep_pkg::EW_KILL;
          cmd.alive_dec    = 1'b1;
          cmd.deg_rd       = 1'b1;
          cmd.deg_src_edge = 1'b1;
          state_nxt        = S_P2_WA;
        end else begin
          if (state_r == S_P2_WB) begin
            cmd.deg_wr       = 1'b1;
            cmd.deg_src_edge = 1'b1;
            cmd.deg_sel_b    = 1'b1;
            cmd.deg_mode     = glep_pkg::DEG_DEC;
          end
          if (sts.ecnt_last) begin
            cmd.ecnt_clr = 1'b1;
            cmd.any_clr  = 1'b1;
            state_nxt    = S_P1_RD;
          end else begin
            cmd.ecnt_inc = 1'b1;
            state_nxt    = S_P2_RD;
          end
        end
      end
      S_P2_WA: begin
        cmd.deg_wr       = 1'b1;
        cmd.deg_src_edge = 1'b1;
        cmd.deg_mode     = glep_pkg::DEG_DEC;
        state_nxt        = S_P2_RB;
      end
      S_P2_RB: begin
        cmd.deg_rd       = 1'b1;
        cmd.deg_src_edge = 1'b1;
        cmd.deg_sel_b    = 1'b1;
        state_nxt        = S_P2_WB;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      resp_clr_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      resp_clr_r <= resp_clr_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
